FILE: hdl/ccst_pkg.sv
// shared constants, types and the gcd step function of the cuboid candidate test
// no dependencies
`default_nettype none
package ccst_pkg;
  localparam int COORD_BITS = 21;
  localparam int TAG_BITS   = 21;
  localparam int W2   = 2 * COORD_BITS;
  localparam int SW   = W2 + 1;
  localparam int XW   = 3 * COORD_BITS;
  localparam int ABW  = 4 * COORD_BITS + 1;
  localparam int CH   = (ABW + 2) / 3;
  localparam int PPW  = CH + COORD_BITS;
  localparam int QW   = CH + W2 + 1;
  localparam int RW   = 6 * COORD_BITS + 2;
  localparam int RT   = RW / 2;
  localparam int RMW  = RT + 3;
  localparam int GS   = 4 * COORD_BITS;
  localparam int GCD_LAT  = 2 * GS;
  localparam int PROD_LAT = 7;
  localparam int ALIGN    = GCD_LAT - PROD_LAT - RT;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [TAG_BITS-1:0]   tag_t;

  typedef struct packed {
    logic          valid;
    logic          order;
    logic          family;
    logic [XW-1:0] xyz;
    tag_t          tag;
  } side_t;

  typedef struct packed {
    logic valid;
    logic order;
    logic family;
    logic exact;
    logic qpos;
    tag_t tag;
  } fin_t;

  typedef struct packed {
    coord_t a;
    coord_t b;
  } gcd_st_t;

  // one binary gcd step on the odd part, a kept odd once its twos are gone
  function automatic gcd_st_t gcd_step(coord_t a, coord_t b);
    gcd_st_t r;
    r.a = a;
    r.b = b;
    if (!a[0]) begin
      r.a = a >> 1;
    end else if (b != '0) begin
      if (!b[0]) begin
        r.b = b >> 1;
      end else if (a > b) begin
        r.a = b;
        r.b = a - b;
      end else begin
        r.b = b - a;
      end
    end
    return r;
  endfunction
endpackage
`default_nettype wire

FILE: hdl/cuboid_candidate_square_test_unit.sv
// cuboid candidate square test: the latency is set by the one-step-per-stage gcd
// pipeline; the root pipeline runs beside it
// throughput one triple per cycle, busy is never raised and nothing is stored
// synchronous active-low reset clears the valid bits and the output hit and q flags
// depends on ccst_pkg, ccst_prod, ccst_sqrt, ccst_gcd
`default_nettype none
module cuboid_candidate_square_test_unit (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire ccst_pkg::coord_t in_coord_x,
  input  wire ccst_pkg::coord_t in_coord_y,
  input  wire ccst_pkg::coord_t in_coord_z,
  input  wire ccst_pkg::tag_t   in_line_tag,
  output logic                  out_valid,
  output logic                  out_hit,
  output logic                  out_q_positive,
  output ccst_pkg::tag_t        out_tag_out
);
  import ccst_pkg::*;

  logic   v0_r;
  coord_t x0_r, y0_r, z0_r;
  tag_t   tag0_r;
  logic [RW-1:0] r_w;
  side_t  side_p, side_s;
  logic [RT-1:0] root_w;
  logic   rem_zero_w, coprime_w;
  fin_t   dl_r [ALIGN];
  logic   out_valid_r, out_hit_r, out_q_r;
  tag_t   out_tag_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    v0_r   <= start;
    x0_r   <= in_coord_x;
    y0_r   <= in_coord_y;
    z0_r   <= in_coord_z;
    tag0_r <= in_line_tag;
    if (!rst_n) begin
      v0_r <= 1'b0;
    end
  end

  ccst_prod u_prod (
    .clk(clk), .rst_n(rst_n), .in_v(v0_r), .x(x0_r), .y(y0_r), .z(z0_r),
    .tag(tag0_r), .r_out(r_w), .side_out(side_p)
  );

  ccst_sqrt u_sqrt (
    .r_in(r_w), .side_in(side_p), .clk(clk), .rst_n(rst_n),
    .root_out(root_w), .rem_zero(rem_zero_w), .side_out(side_s)
  );

  ccst_gcd u_gcd (
    .clk(clk), .x(x0_r), .y(y0_r), .z(z0_r), .coprime(coprime_w)
  );

  always_ff @(posedge clk) begin
    dl_r[0].valid  <= side_s.valid;
    dl_r[0].order  <= side_s.order;
    dl_r[0].family <= side_s.family;
    dl_r[0].exact  <= rem_zero_w;
    dl_r[0].qpos   <= (RT + 1)'(side_s.xyz) > (RT + 1)'(root_w);
    dl_r[0].tag    <= side_s.tag;
    for (int i = 1; i < ALIGN; i++) begin
      dl_r[i] <= dl_r[i-1];
    end
    out_valid_r <= dl_r[ALIGN-1].valid;
    out_hit_r   <= dl_r[ALIGN-1].valid && dl_r[ALIGN-1].order && dl_r[ALIGN-1].exact
                   && dl_r[ALIGN-1].family && coprime_w;
    out_q_r     <= dl_r[ALIGN-1].valid && dl_r[ALIGN-1].order && dl_r[ALIGN-1].exact
                   && dl_r[ALIGN-1].family && coprime_w && dl_r[ALIGN-1].qpos;
    out_tag_r   <= dl_r[ALIGN-1].tag;
    if (!rst_n) begin
      for (int i = 0; i < ALIGN; i++) begin
        dl_r[i].valid <= 1'b0;
      end
      out_valid_r <= 1'b0;
      out_hit_r   <= 1'b0;
      out_q_r     <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_q_positive = out_q_r;
  assign out_tag_out    = out_tag_r;
endmodule
`default_nettype wire

FILE: hdl/ccst_prod.sv
// product pipeline: squares, differences and the exact radicand in split multiplies
// depends on ccst_pkg
`default_nettype none
module ccst_prod (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_v,
  input  wire ccst_pkg::coord_t    x,
  input  wire ccst_pkg::coord_t    y,
  input  wire ccst_pkg::coord_t    z,
  input  wire ccst_pkg::tag_t      tag,
  output logic [ccst_pkg::RW-1:0]  r_out,
  output ccst_pkg::side_t          side_out
);
  import ccst_pkg::*;

  side_t s1_r, s2_r, s3_r, s4_r, s5_r, s6_r, s7_r;
  logic [W2-1:0] xx_r, yy_r, zz_r, xz_r, xy_r;
  coord_t z1_r;
  logic [SW-1:0] sum_r;
  logic [W2-1:0] d1_r, d2_r, d2b_r, d2c_r;
  logic [SW+COORD_BITS-1:0] p0_r, p1_r;
  logic [ABW-1:0] ab_r;
  logic [PPW-1:0] pp_r [3][2];
  logic [PPW-1:0] pp_nxt [3][2];
  logic [QW-1:0] q_r [3];
  logic [QW-1:0] q_nxt [3];
  logic [RW-1:0] r_r;
  logic [3*CH-1:0] abp;

  always_comb begin
    abp = (3 * CH)'(ab_r);
    for (int j = 0; j < 3; j++) begin
      for (int h = 0; h < 2; h++) begin
        pp_nxt[j][h] = PPW'(abp[j*CH +: CH]) * PPW'(d2c_r[h*COORD_BITS +: COORD_BITS]);
      end
      q_nxt[j] = QW'(pp_r[j][0]) + (QW'(pp_r[j][1]) << COORD_BITS);
    end
  end

  always_ff @(posedge clk) begin
    s1_r.valid  <= in_v;
    s1_r.order  <= (x > y) && (y > z) && (z != '0);
    s1_r.family <= 1'b0;
    s1_r.xyz    <= '0;
    s1_r.tag    <= tag;
    xx_r <= W2'(x) * W2'(x);
    yy_r <= W2'(y) * W2'(y);
    zz_r <= W2'(z) * W2'(z);
    xz_r <= W2'(x) * W2'(z);
    xy_r <= W2'(x) * W2'(y);
    z1_r <= z;

    s2_r.valid  <= s1_r.valid;
    s2_r.order  <= s1_r.order;
    s2_r.tag    <= s1_r.tag;
    s2_r.family <= yy_r != xz_r;
    s2_r.xyz    <= XW'(xy_r) * XW'(z1_r);
    sum_r <= SW'(xx_r) + SW'(yy_r);
    d1_r  <= xx_r - zz_r;
    d2_r  <= yy_r - zz_r;

    s3_r  <= s2_r;
    p0_r  <= (SW + COORD_BITS)'(sum_r) * (SW + COORD_BITS)'(d1_r[COORD_BITS-1:0]);
    p1_r  <= (SW + COORD_BITS)'(sum_r) * (SW + COORD_BITS)'(d1_r[W2-1:COORD_BITS]);
    d2b_r <= d2_r;

    s4_r  <= s3_r;
    ab_r  <= ABW'(p0_r) + (ABW'(p1_r) << COORD_BITS);
    d2c_r <= d2b_r;

    s5_r  <= s4_r;
    pp_r  <= pp_nxt;

    s6_r  <= s5_r;
    q_r   <= q_nxt;

    s7_r  <= s6_r;
    r_r   <= RW'(q_r[0]) + (RW'(q_r[1]) << CH) + (RW'(q_r[2]) << (2 * CH));

    if (!rst_n) begin
      s1_r.valid <= 1'b0;
      s2_r.valid <= 1'b0;
      s3_r.valid <= 1'b0;
      s4_r.valid <= 1'b0;
      s5_r.valid <= 1'b0;
      s6_r.valid <= 1'b0;
      s7_r.valid <= 1'b0;
    end
  end

  assign r_out    = r_r;
  assign side_out = s7_r;
endmodule
`default_nettype wire

FILE: hdl/ccst_sqrt.sv
// digit-by-digit square root, one result bit per pipeline stage
// depends on ccst_pkg
`default_nettype none
module ccst_sqrt (
  input  wire logic [ccst_pkg::RW-1:0] r_in,
  input  wire ccst_pkg::side_t         side_in,
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  output logic [ccst_pkg::RT-1:0]      root_out,
  output logic                         rem_zero,
  output ccst_pkg::side_t              side_out
);
  import ccst_pkg::*;

  logic [RMW-1:0] rem_r  [RT];
  logic [RT-1:0]  root_r [RT];
  logic [RW-1:0]  n_r    [RT];
  side_t          sd_r   [RT];

  for (genvar i = 0; i < RT; i++) begin : g_stage
    logic [RMW-1:0] rem_p, rs, t;
    logic [RT-1:0]  root_p;
    logic [RW-1:0]  n_p;
    side_t          sd_p;
    always_comb begin
      if (i == 0) begin
        rem_p  = '0;
        root_p = '0;
        n_p    = r_in;
        sd_p   = side_in;
      end else begin
        rem_p  = rem_r[(i == 0) ? 0 : i - 1];
        root_p = root_r[(i == 0) ? 0 : i - 1];
        n_p    = n_r[(i == 0) ? 0 : i - 1];
        sd_p   = sd_r[(i == 0) ? 0 : i - 1];
      end
      rs = {rem_p[RMW-3:0], n_p[RW-1 -: 2]};
      t  = RMW'({root_p, 2'b01});
    end
    always_ff @(posedge clk) begin
      n_r[i]  <= n_p << 2;
      sd_r[i] <= sd_p;
      if (rs >= t) begin
        rem_r[i]  <= rs - t;
        root_r[i] <= {root_p[RT-2:0], 1'b1};
      end else begin
        rem_r[i]  <= rs;
        root_r[i] <= {root_p[RT-2:0], 1'b0};
      end
      if (!rst_n) begin
        sd_r[i].valid <= 1'b0;
      end
    end
  end

  assign root_out = root_r[RT-1];
  assign rem_zero = rem_r[RT-1] == '0;
  assign side_out = sd_r[RT-1];
endmodule
`default_nettype wire

FILE: hdl/ccst_gcd.sv
// pipelined binary gcd over the three coordinates, one step per stage
// depends on ccst_pkg (gcd_step)
`default_nettype none
module ccst_gcd (
  input  wire logic             clk,
  input  wire ccst_pkg::coord_t x,
  input  wire ccst_pkg::coord_t y,
  input  wire ccst_pkg::coord_t z,
  output logic                  coprime
);
  import ccst_pkg::*;

  coord_t  a_r  [GCD_LAT];
  coord_t  b_r  [GCD_LAT];
  coord_t  z_r  [GS];
  logic    ne_r [GCD_LAT];

  for (genvar k = 0; k < GCD_LAT; k++) begin : g_stage
    gcd_st_t st;
    always_comb begin
      if (k == 0) begin
        st = gcd_step(x, y);
      end else if (k == GS) begin
        st = gcd_step(a_r[(k == 0) ? 0 : k - 1], z_r[GS-1]);
      end else begin
        st = gcd_step(a_r[(k == 0) ? 0 : k - 1], b_r[(k == 0) ? 0 : k - 1]);
      end
    end
    always_ff @(posedge clk) begin
      a_r[k] <= st.a;
      b_r[k] <= st.b;
      if (k == 0) begin
        ne_r[k] <= x[0] | y[0] | z[0];
      end else begin
        ne_r[k] <= ne_r[(k == 0) ? 0 : k - 1];
      end
    end
    if (k < GS) begin : g_z
      always_ff @(posedge clk) begin
        if (k == 0) begin
          z_r[k] <= z;
        end else begin
          z_r[k] <= z_r[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  assign coprime = ne_r[GCD_LAT-1] && (a_r[GCD_LAT-1] == coord_t'(1));
endmodule
`default_nettype wire

FILE: hdl/ccst_checker.sv
// port-level checks of the cuboid candidate test unit and their bind
// depends on cuboid_candidate_square_test_unit
`default_nettype none
module ccst_checker (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             busy,
  input wire logic             out_valid,
  input wire logic             out_hit,
  input wire logic             out_q_positive
);

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_q_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_q_positive |-> out_hit && out_valid)
    else $error("q_positive without hit");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !out_hit && !out_q_positive)
    else $error("result flags without transfer");

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("transfer right after reset");
endmodule

bind cuboid_candidate_square_test_unit ccst_checker u_ccst_checker (.*);
`default_nettype wire

FILE: tb/sv/tb.sv
// testbench for cuboid_candidate_square_test_unit: directed and random triples,
// expected hit and q_positive worked out per transfer and checked in order
// depends on ccst_pkg and the unit under test
`default_nettype none
module tb;
  import ccst_pkg::*;

  typedef struct packed {
    logic hit;
    logic qpos;
    tag_t tag;
  } verdict_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } triple_t;

  logic   clk;
  logic   rst_n;
  logic   start;
  logic   busy;
  coord_t in_coord_x;
  coord_t in_coord_y;
  coord_t in_coord_z;
  tag_t   in_line_tag;
  logic   out_valid;
  logic   out_hit;
  logic   out_q_positive;
  tag_t   out_tag_out;

  verdict_t pending_verdicts[$];
  triple_t  hit_triples[$];
  triple_t  family_triples[$];
  int       mismatches;
  int       sent_count;
  int       seen_count;
  int       seen_hits;

  cuboid_candidate_square_test_unit u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_coord_x(in_coord_x), .in_coord_y(in_coord_y), .in_coord_z(in_coord_z),
    .in_line_tag(in_line_tag), .out_valid(out_valid), .out_hit(out_hit),
    .out_q_positive(out_q_positive), .out_tag_out(out_tag_out)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic longint unsigned gcd64(longint unsigned a, longint unsigned b);
    longint unsigned t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // integer square root of the product, exact flag in bit 64
  function automatic logic [64:0] root128(logic [127:0] n);
    logic [129:0] rem;
    logic [129:0] trial;
    logic [63:0]  root;
    rem  = '0;
    root = '0;
    for (int i = 63; i >= 0; i--) begin
      rem   = (rem << 2) | n[2*i +: 2];
      trial = {root, 2'b01};
      if (rem >= trial) begin
        rem  = rem - trial;
        root = {root[62:0], 1'b1};
      end else begin
        root = {root[62:0], 1'b0};
      end
    end
    return {(rem == 0), root};
  endfunction

  function automatic verdict_t judge_triple(coord_t cx, coord_t cy, coord_t cz, tag_t tag);
    verdict_t v;
    longint unsigned x, y, z, xx, yy, zz;
    logic [127:0] r;
    logic [64:0]  sq;
    x = cx;
    y = cy;
    z = cz;
    v.hit  = 1'b0;
    v.qpos = 1'b0;
    v.tag  = tag;
    if (x > y && y > z && z > 0) begin
      xx = x * x;
      yy = y * y;
      zz = z * z;
      r  = 128'(xx + yy) * 128'(xx - zz) * 128'(yy - zz);
      sq = root128(r);
      if (sq[64] && gcd64(gcd64(x, y), z) == 1 && yy != x * z) begin
        v.hit  = 1'b1;
        v.qpos = ((x * y * z) > sq[63:0]);
      end
    end
    return v;
  endfunction

  task automatic send_triple(coord_t x, coord_t y, coord_t z, tag_t tag);
    int gap;
    gap = $urandom_range(0, 10);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    in_coord_x  <= x;
    in_coord_y  <= y;
    in_coord_z  <= z;
    in_line_tag <= tag;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    pending_verdicts.push_back(judge_triple(x, y, z, tag));
    sent_count++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  function automatic tag_t rand_tag();
    return tag_t'($urandom());
  endfunction

  // small triples that pass every test, plus the excluded y*y == x*z family
  task automatic find_small_triples();
    verdict_t v;
    for (int x = 3; x <= 64; x++)
      for (int y = 2; y < x; y++)
        for (int z = 1; z < y; z++) begin
          if (y * y == x * z) begin
            family_triples.push_back({coord_t'(x), coord_t'(y), coord_t'(z)});
          end else begin
            v = judge_triple(coord_t'(x), coord_t'(y), coord_t'(z), '0);
            if (v.hit) hit_triples.push_back({coord_t'(x), coord_t'(y), coord_t'(z)});
          end
        end
  endtask

  task automatic test_edge_cases();
    triple_t t;
    send_triple('0, '0, '0, '0);
    send_triple('1, '1, '1, '1);
    send_triple('1, coord_t'(2097150), coord_t'(2097149), '1);
    send_triple(coord_t'(3), coord_t'(2), coord_t'(1), '0);
    send_triple(coord_t'(3), coord_t'(2), coord_t'(0), tag_t'(5));
    send_triple(coord_t'(2), coord_t'(3), coord_t'(1), tag_t'(6));
    send_triple(coord_t'(3), coord_t'(3), coord_t'(1), tag_t'(7));
    send_triple(coord_t'(3), coord_t'(2), coord_t'(2), tag_t'(8));
    send_triple(coord_t'(4), coord_t'(2), coord_t'(1), tag_t'(9));
    send_triple(coord_t'(8), coord_t'(4), coord_t'(2), tag_t'(10));
    send_triple('1, coord_t'(2), coord_t'(1), tag_t'(11));
    send_triple('1, coord_t'(2097150), coord_t'(1), tag_t'(12));
    for (int i = 0; i < hit_triples.size() && i < 6; i++) begin
      t = hit_triples[i];
      send_triple(t.x, t.y, t.z, rand_tag());
      send_triple(coord_t'(t.x * 2), coord_t'(t.y * 2), coord_t'(t.z * 2), rand_tag());
    end
  endtask

  task automatic test_random_mix(int count);
    triple_t t;
    coord_t  a, b, c;
    int      k;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          if (hit_triples.size() != 0) begin
            t = hit_triples[$urandom_range(0, hit_triples.size() - 1)];
            k = $urandom_range(1, 3);
            send_triple(coord_t'(t.x * k), coord_t'(t.y * k), coord_t'(t.z * k),
                        rand_tag());
          end else begin
            send_triple(coord_t'(5), coord_t'(4), coord_t'(3), rand_tag());
          end
        end
        2: begin
          t = family_triples[$urandom_range(0, family_triples.size() - 1)];
          send_triple(t.x, t.y, t.z, rand_tag());
        end
        3, 4: begin
          a = coord_t'($urandom_range(3, 200));
          b = coord_t'($urandom_range(2, a - 1));
          c = coord_t'($urandom_range(1, b - 1));
          send_triple(a, b, c, rand_tag());
        end
        5, 6, 7: begin
          a = coord_t'($urandom_range(3, 2097151));
          b = coord_t'($urandom_range(2, a - 1));
          c = coord_t'($urandom_range(1, b - 1));
          send_triple(a, b, c, rand_tag());
        end
        default: begin
          send_triple(coord_t'($urandom()), coord_t'($urandom()), coord_t'($urandom()),
                      rand_tag());
        end
      endcase
    end
  endtask

  task automatic test_pause_until_empty();
    test_random_mix(20);
    drain_results();
    repeat ($urandom_range(1, 10)) @(posedge clk);
    test_random_mix(20);
  endtask

  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_valid) begin
      seen_count++;
      if (out_hit) seen_hits++;
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: hit=%0b q=%0b tag=%0h",
                                       out_hit, out_q_positive, out_tag_out);
      end else begin
        want = pending_verdicts.pop_front();
        if (out_hit !== want.hit || out_q_positive !== want.qpos || out_tag_out !== want.tag)
        begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected hit=%0b q=%0b tag=%0h, got hit=%0b q=%0b tag=%0h",
                     want.hit, want.qpos, want.tag, out_hit, out_q_positive, out_tag_out);
        end
      end
    end
  end

  initial begin
    #3_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    mismatches  = 0;
    sent_count  = 0;
    seen_count  = 0;
    seen_hits   = 0;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_coord_x  = '0;
    in_coord_y  = '0;
    in_coord_z  = '0;
    in_line_tag = '0;
    find_small_triples();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_edge_cases();
    test_pause_until_empty();
    test_random_mix(590);
    drain_results();
    repeat (2 * GCD_LAT + 20) @(posedge clk);
    $display("sent %0d triples, %0d results, %0d hits (%0d small hit triples known)",
             sent_count, seen_count, seen_hits, hit_triples.size());
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
